// ===== rtl/wpm_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wpm_pkg
// Shared codes and types for the wildcard pattern matcher and its cells.
// ---------------------------------------------------------------------------
package wpm_pkg;

    // word kinds on the input stream
    typedef enum logic [1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_APPEND = 2'd1,
        KIND_TEXT   = 2'd2,
        KIND_END    = 2'd3
    } t_kind;

    localparam int unsigned SYM_STAR  = 42;
    localparam int unsigned SYM_QMARK = 63;

    // per-cycle control broadcast to every cell
    typedef struct packed {
        logic restart;  // return the active set to position zero
        logic step;     // advance the active set by one text symbol
        logic write;    // store the symbol in the cell at the pattern end
    } t_cell_ctl;

endpackage

// ===== rtl/wpm_cell.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wpm_cell
// One pattern position: holds its symbol and active bit, forwards the star
// closure and the advance bit to its right neighbour.
// ---------------------------------------------------------------------------
module wpm_cell #(
    parameter int unsigned LEN_W = 6,
    parameter int unsigned SYM_W = 16,
    parameter int unsigned INDEX = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  wpm_pkg::t_cell_ctl i_ctl,
    input  logic [LEN_W-1:0]   i_len,
    input  logic [SYM_W-1:0]   i_sym,
    input  logic               i_carry,
    input  logic               i_adv,
    output logic               o_carry,
    output logic               o_adv,
    output logic               o_cl
);
    import wpm_pkg::*;

    localparam logic [LEN_W-1:0] IDX   = LEN_W'(INDEX);
    localparam logic [SYM_W-1:0] STAR  = SYM_W'(SYM_STAR);
    localparam logic [SYM_W-1:0] QMARK = SYM_W'(SYM_QMARK);
    localparam logic             FIRST = (INDEX == 0);

    logic [SYM_W-1:0] r_sym;
    logic             r_act;
    logic             n_act;
    logic             in_pat;
    logic             is_star;
    logic             hit;

    assign in_pat  = (i_len > IDX);
    assign is_star = (r_sym == STAR);
    assign hit     = (r_sym == QMARK) || (r_sym == i_sym);
    assign o_cl    = r_act | i_carry;
    assign o_carry = o_cl & in_pat & is_star;
    assign o_adv   = o_cl & in_pat & !is_star & hit;

    always_comb begin
        n_act = r_act;
        if (i_ctl.restart) begin
            n_act = FIRST;
        end else if (i_ctl.step) begin
            // a star keeps itself alive, a match arrives from the left
            n_act = o_carry | i_adv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= FIRST;
        end else begin
            r_act <= n_act;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.write && (i_len == IDX)) begin
            r_sym <= i_sym;
        end
    end

endmodule

// ===== rtl/wildcard_pattern_matcher.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wildcard_pattern_matcher
// Glob matcher with star and question mark, built as a row of position cells.
// ---------------------------------------------------------------------------
//
//  channel  | dir | tdata                     | tuser
//  ---------+-----+---------------------------+-------------
//  s_axis   | in  | [15:0] symbol             | [1:0] kind
//  m_axis   | out | [0] match, [1] overflow   | -
//
//  Input words are taken back to back unless the input stalls (see
//  below). The star closure ripples through the cell row in the same
//  cycle as the update, like a carry chain, and sets the clock period.
//  Reset leaves an empty pattern and the active set at position zero; no
//  clearing pass is needed. An end-of-text verdict waits in the output
//  register; the input stalls only while that register is full and the
//  output side holds tready low.
// ---------------------------------------------------------------------------
module wildcard_pattern_matcher #(
    parameter int unsigned MAX_PATTERN = 32,
    parameter int unsigned SYMBOL_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] symbol
    input  logic [1:0]  s_axis_tuser,   // [1:0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [0] match, [1] pattern_overflow, rest zero
);
    import wpm_pkg::*;

    localparam int unsigned LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int unsigned SYM_W = SYMBOL_BITS;
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PATTERN);
    localparam logic [SYM_W-1:0] STAR    = SYM_W'(SYM_STAR);

    // pattern bookkeeping
    logic [LEN_W-1:0] r_len,        n_len;
    logic [LEN_W-1:0] r_trail,      n_trail;    // start of trailing star group
    logic             r_last_star,  n_last_star;
    logic             r_ovf,        n_ovf;
    logic             r_trail_hit,  n_trail_hit;
    logic             r_act_end,    n_act_end;  // active bit of the final position

    // output register
    logic             r_out_valid,  n_out_valid;
    logic             r_out_match,  n_out_match;
    logic             r_out_ovf,    n_out_ovf;

    logic             accept;
    t_kind            kind;
    logic [31:0]      sym_ext;
    logic [SYM_W-1:0] sym;
    logic             sym_nz;
    t_cell_ctl        ctl;

    logic [MAX_PATTERN:0]   carry;   // carry[p] enters cell p
    logic [MAX_PATTERN:0]   adv;
    logic [MAX_PATTERN:0]   cl;      // star closure of the active set
    logic                   verdict;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign kind          = t_kind'(s_axis_tuser);
    assign sym_ext       = {16'b0, s_axis_tdata};
    assign sym           = sym_ext[SYM_W-1:0];
    assign sym_nz        = (sym != '0);

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_out_ovf, r_out_match};

    // broadcast control for the cell row
    always_comb begin
        ctl.restart = 1'b0;
        ctl.step    = 1'b0;
        ctl.write   = 1'b0;
        if (accept) begin
            case (kind)
                KIND_CLEAR, KIND_END: ctl.restart = 1'b1;
                KIND_APPEND: begin
                    ctl.restart = 1'b1;
                    ctl.write   = sym_nz && (r_len < LEN_MAX);
                end
                KIND_TEXT:   ctl.step = sym_nz;
                default:     ctl.restart = 1'b0;
            endcase
        end
    end

    // the cell row
    assign carry[0] = 1'b0;
    assign adv[0]   = 1'b0;

    for (genvar p = 0; p < MAX_PATTERN; p++) begin : g_cell
        wpm_cell #(
            .LEN_W (LEN_W),
            .SYM_W (SYM_W),
            .INDEX (p)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_len   (r_len),
            .i_sym   (sym),
            .i_carry (carry[p]),
            .i_adv   (adv[p]),
            .o_carry (carry[p+1]),
            .o_adv   (adv[p+1]),
            .o_cl    (cl[p])
        );
    end

    assign cl[MAX_PATTERN] = r_act_end | carry[MAX_PATTERN];

    // match at the pattern end; a trailing group of two or more stars needs
    // a text symbol seen while that group was already reached
    always_comb begin
        verdict = cl[r_len];
        if ((r_len - r_trail) >= LEN_W'(2)) begin
            verdict = verdict && r_trail_hit;
        end
        if (r_ovf) begin
            verdict = 1'b0;
        end
    end

    always_comb begin
        n_len       = r_len;
        n_trail     = r_trail;
        n_last_star = r_last_star;
        n_ovf       = r_ovf;
        n_trail_hit = r_trail_hit;
        n_act_end   = r_act_end;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_match = r_out_match;
        n_out_ovf   = r_out_ovf;

        if (ctl.restart) begin
            n_trail_hit = 1'b0;
            n_act_end   = (MAX_PATTERN == 0);
        end

        if (accept) begin
            case (kind)
                KIND_CLEAR: begin
                    n_len       = '0;
                    n_trail     = '0;
                    n_last_star = 1'b0;
                    n_ovf       = 1'b0;
                end
                KIND_APPEND: begin
                    if (sym_nz) begin
                        if (r_len >= LEN_MAX) begin
                            n_ovf = 1'b1;
                        end else begin
                            n_len       = r_len + LEN_W'(1);
                            n_last_star = (sym == STAR);
                            if (sym != STAR) begin
                                n_trail = r_len + LEN_W'(1);
                            end else if (!r_last_star) begin
                                n_trail = r_len;
                            end
                        end
                    end
                end
                KIND_TEXT: begin
                    if (sym_nz) begin
                        if ((r_trail < r_len) && cl[r_trail]) begin
                            n_trail_hit = 1'b1;
                        end
                        n_act_end = adv[MAX_PATTERN];
                    end
                end
                KIND_END: begin
                    n_out_valid = 1'b1;
                    n_out_match = verdict;
                    n_out_ovf   = r_ovf;
                end
                default: n_len = r_len;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_trail     <= '0;
            r_last_star <= 1'b0;
            r_ovf       <= 1'b0;
            r_trail_hit <= 1'b0;
            r_act_end   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_len       <= n_len;
            r_trail     <= n_trail;
            r_last_star <= n_last_star;
            r_ovf       <= n_ovf;
            r_trail_hit <= n_trail_hit;
            r_act_end   <= n_act_end;
            r_out_valid <= n_out_valid;
        end
    end

    // payload of the verdict word
    always_ff @(posedge i_clk) begin
        r_out_match <= n_out_match;
        r_out_ovf   <= n_out_ovf;
    end

endmodule

// ===== tb/wildcard_pattern_matcher_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wildcard_pattern_matcher_tb
// Self-checking bench for the star / question-mark glob matcher. A local
// predictor tracks the pattern, the active position set and the overflow
// flag; every end-of-text verdict from the block is checked against it.
// ---------------------------------------------------------------------------
module wildcard_pattern_matcher_tb;
    import wpm_pkg::*;

    localparam int unsigned MAX_PATTERN    = 32;
    localparam int unsigned SYMBOL_BITS    = 16;
    localparam int unsigned WATCHDOG_LIMIT = 2000;  // cycles without any handshake
    localparam int unsigned DRAIN_CYCLES   = 16;
    localparam int unsigned RANDOM_WORDS   = 1200;

    localparam logic [15:0] CODE_STAR  = 16'(SYM_STAR);
    localparam logic [15:0] CODE_QMARK = 16'(SYM_QMARK);
    localparam logic [15:0] CODE_NONE  = 16'h0000;
    localparam logic [15:0] CODE_A     = 16'h0061;
    localparam logic [15:0] CODE_B     = 16'h0062;
    localparam logic [15:0] CODE_C     = 16'h0063;
    localparam logic [15:0] CODE_X     = 16'h0078;
    localparam logic [15:0] CODE_Z     = 16'h007a;
    localparam logic [15:0] CODE_TOP   = 16'hffff;

    localparam logic [MAX_PATTERN:0] LIVE_START = {{MAX_PATTERN{1'b0}}, 1'b1};

    typedef struct packed {
        logic hit;
        logic ovf;
    } t_verdict;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;     // [15:0] symbol
    logic [1:0]  s_axis_tuser  = '0;     // [1:0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;           // [0] match, [1] pattern_overflow, [7:2] zero

    // glob state as the predictor sees it
    logic [15:0]        pat_sym [MAX_PATTERN];
    int unsigned        pat_len   = 0;
    logic [MAX_PATTERN:0] live    = LIVE_START;
    logic               pat_ovf   = 1'b0;
    logic               tail_seen = 1'b0;

    t_verdict    verdicts_due[$];
    logic [15:0] text_buf[$];

    bit          quiet       = 1'b0;
    int unsigned errors      = 0;
    int unsigned words_sent  = 0;
    int unsigned verdicts_in = 0;
    int unsigned hits_in     = 0;
    int unsigned ovf_in      = 0;
    int unsigned longest_pat = 0;
    int unsigned idle_cycles = 0;
    int unsigned out_hold    = 0;

    wildcard_pattern_matcher #(
        .MAX_PATTERN (MAX_PATTERN),
        .SYMBOL_BITS (SYMBOL_BITS)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // -----------------------------------------------------------------------
    // Predictor
    // -----------------------------------------------------------------------

    function automatic void restart_text();
        live      = LIVE_START;
        tail_seen = 1'b0;
    endfunction

    // active set with every star allowed to match an empty run
    function automatic logic [MAX_PATTERN:0] star_closure();
        logic [MAX_PATTERN:0] cl;
        cl = live;
        for (int p = 0; p < pat_len; p++)
            if (cl[p] && pat_sym[p] == CODE_STAR)
                cl[p + 1] = 1'b1;
        return cl;
    endfunction

    // first position of the trailing run of stars, pat_len if none
    function automatic int unsigned tail_group_start();
        int unsigned g;
        g = pat_len;
        while (g > 0 && pat_sym[g - 1] == CODE_STAR)
            g--;
        return g;
    endfunction

    task automatic glob_advance(input t_kind kind, input logic [15:0] sym);
        logic [MAX_PATTERN:0] cl;
        int unsigned          g;
        t_verdict             v;
        case (kind)
            KIND_CLEAR: begin
                pat_len = 0;
                pat_ovf = 1'b0;
                restart_text();
            end
            KIND_APPEND: begin
                if (sym != CODE_NONE) begin
                    if (pat_len >= MAX_PATTERN) begin
                        pat_ovf = 1'b1;
                    end else begin
                        pat_sym[pat_len] = sym;
                        pat_len++;
                        if (pat_len > longest_pat)
                            longest_pat = pat_len;
                    end
                end
                restart_text();
            end
            KIND_TEXT: begin
                if (sym != CODE_NONE) begin
                    cl = star_closure();
                    g  = tail_group_start();
                    if (g < pat_len && cl[g])
                        tail_seen = 1'b1;
                    live = '0;
                    for (int p = 0; p < pat_len; p++) begin
                        if (cl[p]) begin
                            if (pat_sym[p] == CODE_STAR)
                                live[p] = 1'b1;
                            else if (pat_sym[p] == CODE_QMARK || pat_sym[p] == sym)
                                live[p + 1] = 1'b1;
                        end
                    end
                end
            end
            KIND_END: begin
                cl    = star_closure();
                g     = tail_group_start();
                v.hit = cl[pat_len];
                // text ending right at a trailing group of two or more stars
                // only counts if a symbol was eaten inside that group
                if (pat_len - g >= 2)
                    v.hit = v.hit && tail_seen;
                if (pat_ovf)
                    v.hit = 1'b0;
                v.ovf = pat_ovf;
                verdicts_due = {verdicts_due, v};
                restart_text();
            end
        endcase
    endtask

    // -----------------------------------------------------------------------
    // Idling
    // -----------------------------------------------------------------------

    // mostly short gaps, the odd long one
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70)
            return $urandom_range(1, 2);
        else if (r < 95)
            return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    function automatic int unsigned input_gap();
        if (quiet || $urandom_range(99) < 55)
            return 0;
        return gap_len();
    endfunction

    // back-pressure on the verdict side; drop tready in random bursts
    always @(posedge i_clk) begin
        if (out_hold > 0) begin
            out_hold--;
            m_axis_tready <= 1'b0;
        end else if (!quiet && $urandom_range(99) < 20) begin
            out_hold = gap_len() - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // -----------------------------------------------------------------------
    // Word driver: hold the word until the block takes it, then predict
    // -----------------------------------------------------------------------

    task automatic push_word(input t_kind kind, input logic [15:0] sym);
        int unsigned gap;
        gap = input_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sym;
        s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!s_axis_tready);
        words_sent++;
        glob_advance(kind, sym);
    endtask

    // -----------------------------------------------------------------------
    // Verdict checker
    // -----------------------------------------------------------------------

    always @(posedge i_clk) begin
        t_verdict v;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (verdicts_due.size() == 0) begin
                $display("%0t: verdict with none expected, got tdata %02h", $time, m_axis_tdata);
                errors++;
            end else begin
                v = verdicts_due.pop_front();
                verdicts_in++;
                if (v.hit)
                    hits_in++;
                if (v.ovf)
                    ovf_in++;
                if (m_axis_tdata[0] !== v.hit) begin
                    $display("%0t: match expected %0b got %0b", $time, v.hit, m_axis_tdata[0]);
                    errors++;
                end
                if (m_axis_tdata[1] !== v.ovf) begin
                    $display("%0t: pattern_overflow expected %0b got %0b",
                             $time, v.ovf, m_axis_tdata[1]);
                    errors++;
                end
                if (m_axis_tdata[7:2] !== 6'b0) begin
                    $display("%0t: tdata padding expected 00 got %02h", $time, m_axis_tdata[7:2]);
                    errors++;
                end
            end
        end
    end

    // end the run if the block stops moving words on both sides
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired with %0d verdicts outstanding",
                     $time, verdicts_due.size());
            $display("** wildcard_pattern_matcher: FAILED **");
            $finish;
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus generators
    // -----------------------------------------------------------------------

    function automatic logic [15:0] text_sym();
        case ($urandom_range(19))
            0, 1, 2, 3, 4:  return CODE_A;
            5, 6, 7, 8:     return CODE_B;
            9, 10, 11:      return CODE_C;
            12:             return CODE_STAR;
            13:             return CODE_QMARK;
            14:             return CODE_TOP;
            default:        return 16'($urandom_range(1, 16'hffff));
        endcase
    endfunction

    function automatic logic [15:0] pattern_sym();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 35)
            return CODE_STAR;
        else if (r < 50)
            return CODE_QMARK;
        return text_sym();
    endfunction

    // build a text from the loaded pattern that matches it
    task automatic make_matching_text();
        text_buf.delete();
        for (int p = 0; p < pat_len; p++) begin
            if (pat_sym[p] == CODE_STAR)
                repeat ($urandom_range(0, 3)) text_buf = {text_buf, text_sym()};
            else if (pat_sym[p] == CODE_QMARK)
                text_buf = {text_buf, text_sym()};
            else
                text_buf = {text_buf, pat_sym[p]};
        end
    endtask

    task automatic make_text();
        int unsigned r;
        int unsigned idx;
        r = $urandom_range(99);
        if (r < 55) begin
            make_matching_text();
        end else if (r < 80) begin
            // one-symbol edit of a matching text: usually breaks the match
            make_matching_text();
            if (text_buf.size() == 0) begin
                text_buf = {text_buf, text_sym()};
            end else begin
                idx = $urandom_range(text_buf.size() - 1);
                case ($urandom_range(2))
                    0:       text_buf[idx] = text_sym();
                    1:       text_buf.delete(idx);
                    default: text_buf.insert(idx, text_sym());
                endcase
            end
        end else begin
            text_buf.delete();
            repeat ($urandom_range(0, 8)) text_buf = {text_buf, text_sym()};
        end
    endtask

    task automatic stream_text();
        foreach (text_buf[i]) begin
            if ($urandom_range(99) < 3)
                push_word(KIND_TEXT, CODE_NONE);
            push_word(KIND_TEXT, text_buf[i]);
        end
        push_word(KIND_END, text_sym());
    endtask

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------

    task automatic test_basics();
        push_word(KIND_END,    CODE_NONE);    // empty pattern, empty text
        push_word(KIND_TEXT,   CODE_A);
        push_word(KIND_END,    CODE_TOP);     // empty pattern, non-empty text
        push_word(KIND_APPEND, CODE_A);
        push_word(KIND_APPEND, CODE_QMARK);
        push_word(KIND_APPEND, CODE_NONE);    // dropped
        push_word(KIND_APPEND, CODE_C);
        push_word(KIND_TEXT,   CODE_A);
        push_word(KIND_TEXT,   CODE_NONE);    // ignored text symbol
        push_word(KIND_TEXT,   CODE_TOP);
        push_word(KIND_TEXT,   CODE_C);
        push_word(KIND_END,    CODE_NONE);
        push_word(KIND_APPEND, CODE_STAR);
        push_word(KIND_APPEND, CODE_STAR);
        // text stops as the double-star tail is reached: the kept quirk
        push_word(KIND_TEXT,   CODE_A);
        push_word(KIND_TEXT,   CODE_X);
        push_word(KIND_TEXT,   CODE_C);
        push_word(KIND_END,    CODE_NONE);
        // one symbol eaten inside the tail: now a match
        push_word(KIND_TEXT,   CODE_A);
        push_word(KIND_TEXT,   CODE_STAR);
        push_word(KIND_TEXT,   CODE_C);
        push_word(KIND_TEXT,   CODE_Z);
        push_word(KIND_END,    CODE_NONE);
        push_word(KIND_CLEAR,  CODE_TOP);
        push_word(KIND_END,    CODE_NONE);
    endtask

    task automatic test_overflow();
        push_word(KIND_CLEAR, CODE_NONE);
        repeat (MAX_PATTERN - 2) push_word(KIND_APPEND, pattern_sym());
        push_word(KIND_APPEND, CODE_QMARK);
        push_word(KIND_APPEND, CODE_STAR);
        // exactly full: still a normal verdict
        make_matching_text();
        stream_text();
        push_word(KIND_TEXT, CODE_B);
        push_word(KIND_END,  CODE_NONE);
        // one more symbol overflows; matching text must now fail
        push_word(KIND_APPEND, CODE_A);
        push_word(KIND_APPEND, CODE_TOP);
        make_matching_text();
        stream_text();
        push_word(KIND_END,   CODE_NONE);
        // clear drops the flag
        push_word(KIND_CLEAR, CODE_NONE);
        push_word(KIND_END,   CODE_NONE);
    endtask

    task automatic test_random_globs(input int unsigned target);
        int unsigned start;
        int unsigned len;
        int unsigned r;
        start = words_sent;
        while (words_sent - start < target) begin
            quiet = ($urandom_range(99) < 12);
            if ($urandom_range(99) < 85)
                push_word(KIND_CLEAR, 16'($urandom));
            r = $urandom_range(99);
            if (r < 75)
                len = $urandom_range(0, 6);
            else if (r < 95)
                len = $urandom_range(7, 16);
            else
                len = $urandom_range(17, MAX_PATTERN + 4);
            repeat (len) begin
                if ($urandom_range(99) < 5)
                    push_word(KIND_APPEND, CODE_NONE);
                push_word(KIND_APPEND, pattern_sym());
            end
            repeat ($urandom_range(1, 4)) begin
                make_text();
                stream_text();
            end
            // occasional stray words of any kind
            if ($urandom_range(99) < 8)
                repeat ($urandom_range(1, 4))
                    push_word(t_kind'($urandom_range(0, 3)), 16'($urandom));
        end
        quiet = 1'b0;
    endtask

    // -----------------------------------------------------------------------
    // Sequence
    // -----------------------------------------------------------------------

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basics();
        test_overflow();
        test_random_globs(RANDOM_WORDS);

        s_axis_tvalid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d words; checked %0d verdicts, %0d matching, %0d with overflow.",
                 words_sent, verdicts_in, hits_in, ovf_in);
        $display("Longest pattern held %0d symbols; %0d mismatches seen.", longest_pat, errors);
        if (errors == 0) begin
            $display("** wildcard_pattern_matcher: PASSED **");
        end else begin
            $display("** wildcard_pattern_matcher: FAILED **");
        end
        $finish;
    end

endmodule
